>>> hw/rtl/tem_pkg.sv
// ----------------------------------------------------------------------------
// tem_pkg
// Shared widths, register indexes, CORDIC constants and the stage record for
// the twist exponential map datapath.
// ----------------------------------------------------------------------------
package tem_pkg;

    localparam int FRAC_BITS = 16;
    localparam int Q30_SHIFT = 30 - FRAC_BITS;

    localparam int ANGLE_W = 20;
    localparam int AXIS_W  = 18;
    localparam int LIN_W   = 32;
    localparam int ROT_W   = 18;
    localparam int TR_W    = 32;
    localparam int CFG_IDX_W = 3;

    localparam int T_W  = 36;
    localparam int XY_W = 34;

    localparam logic [CFG_IDX_W-1:0] REG_LIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIN_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z = 3'd5;

    localparam logic signed [T_W-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [T_W-1:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [T_W-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [XY_W-1:0] Q30_GAIN   = 34'sd652032875;

    localparam logic signed [T_W-1:0] ATAN_Q30 [32] = '{
        36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159,
        36'sd67021687,  36'sd33543516,  36'sd16775851,  36'sd8388437,
        36'sd4194283,   36'sd2097149,   36'sd1048576,   36'sd524288,
        36'sd262144,    36'sd131072,    36'sd65536,     36'sd32768,
        36'sd16384,     36'sd8192,      36'sd4096,      36'sd2048,
        36'sd1024,      36'sd512,       36'sd256,       36'sd128,
        36'sd64,        36'sd32,        36'sd16,        36'sd8,
        36'sd4,         36'sd2,         36'sd1,         36'sd0
    };

    typedef struct packed {
        logic                      valid;
        logic                      flip;
        logic signed [ANGLE_W-1:0] theta;
        logic signed [XY_W-1:0]    x;
        logic signed [XY_W-1:0]    y;
        logic signed [T_W-1:0]     t;
    } cordic_t;

endpackage

>>> hw/rtl/tem_cordic_cell.sv
// ----------------------------------------------------------------------------
// tem_cordic_cell
// One rotation-mode CORDIC iteration with its own register stage.
// ----------------------------------------------------------------------------
module tem_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  tem_pkg::cordic_t cin,
    output tem_pkg::cordic_t cout
);
    import tem_pkg::*;

    localparam int K = STEP % 32;

    cordic_t c_reg;
    cordic_t c_next;

    always_comb
    begin
        c_next = cin;
        if (!cin.t[T_W-1])
        begin
            c_next.x = cin.x - (cin.y >>> K);
            c_next.y = cin.y + (cin.x >>> K);
            c_next.t = cin.t - ATAN_Q30[K];
        end
        else
        begin
            c_next.x = cin.x + (cin.y >>> K);
            c_next.y = cin.y - (cin.x >>> K);
            c_next.t = cin.t + ATAN_Q30[K];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg <= '0;
        end
        else if (adv)
        begin
            c_reg <= c_next;
        end
    end

    assign cout = c_reg;

endmodule

>>> hw/rtl/tem_twist_terms.sv
// ----------------------------------------------------------------------------
// tem_twist_terms
// Terms that depend on the twist registers only: the squared skew matrix,
// the cross product of axis and linear part, and their dot product.
// ----------------------------------------------------------------------------
module tem_twist_terms (
    input  logic                               clk,
    input  logic signed [tem_pkg::AXIS_W-1:0]  axis [3],
    input  logic signed [tem_pkg::LIN_W-1:0]   lin [3],
    output logic signed [21:0]                 sq [3][3],
    output logic signed [35:0]                 wxv [3],
    output logic signed [35:0]                 dot
);
    import tem_pkg::*;

    logic signed [35:0] ww_reg [3][3];
    logic signed [49:0] wv_reg [3][3];
    logic signed [21:0] sq_reg [3][3];
    logic signed [35:0] wxv_reg [3];
    logic signed [35:0] dot_reg;

    logic signed [37:0] sqp [3][3];
    logic signed [51:0] wxp [3];
    logic signed [51:0] dotp;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                ww_reg[i][j] <= 36'(axis[i]) * 36'(axis[j]);
                wv_reg[i][j] <= 50'(axis[i]) * 50'(lin[j]);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (i == j)
                begin
                    sqp[i][j] = 38'sd32768 - 38'(ww_reg[(i + 1) % 3][(i + 1) % 3])
                              - 38'(ww_reg[(i + 2) % 3][(i + 2) % 3]);
                end
                else
                begin
                    sqp[i][j] = 38'(ww_reg[i][j]) + 38'sd32768;
                end
            end
            wxp[i] = 52'(wv_reg[(i + 1) % 3][(i + 2) % 3])
                   - 52'(wv_reg[(i + 2) % 3][(i + 1) % 3]) + 52'sd32768;
        end
        dotp = 52'(wv_reg[0][0]) + 52'(wv_reg[1][1]) + 52'(wv_reg[2][2]) + 52'sd32768;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                sq_reg[i][j] <= sqp[i][j][37:FRAC_BITS];
            end
            wxv_reg[i] <= wxp[i][51:FRAC_BITS];
        end
        dot_reg <= dotp[51:FRAC_BITS];
    end

    assign sq  = sq_reg;
    assign wxv = wxv_reg;
    assign dot = dot_reg;

endmodule

>>> hw/rtl/tem_post.sv
// ----------------------------------------------------------------------------
// tem_post
// Back end after the CORDIC chain: sine and cosine rounding, rotation
// entries by the Rodrigues formula, translation with saturation, and the
// output register.
// ----------------------------------------------------------------------------
module tem_post (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  tem_pkg::cordic_t                   cin,
    input  logic signed [tem_pkg::AXIS_W-1:0]  axis [3],
    input  logic signed [21:0]                 sq [3][3],
    input  logic signed [35:0]                 wxv [3],
    input  logic signed [35:0]                 dot,
    output logic                               out_valid,
    output logic signed [tem_pkg::ROT_W-1:0]   rot [3][3],
    output logic signed [tem_pkg::TR_W-1:0]    tr [3]
);
    import tem_pkg::*;

    localparam logic signed [29:0] ROT_MAX = 30'sd131071;
    localparam logic signed [29:0] ROT_MIN = -30'sd131072;
    localparam logic signed [45:0] TR_MAX  = 46'sd2147483647;
    localparam logic signed [45:0] TR_MIN  = -46'sd2147483648;

    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [20:0] s1_reg;
    logic signed [21:0] omc1_reg;
    logic signed [40:0] dt1_reg;
    logic signed [23:0] a2_reg [3][3];
    logic signed [28:0] b2_reg [3][3];
    logic signed [43:0] wdt2_reg [3];
    logic signed [ROT_W-1:0] rot3_reg [3][3];
    logic signed [43:0] wdt3_reg [3];
    logic signed [40:0] term4_reg [3][3];
    logic signed [ROT_W-1:0] rot4_reg [3][3];
    logic signed [43:0] wdt4_reg [3];
    logic signed [ROT_W-1:0] rot5_reg [3][3];
    logic signed [TR_W-1:0] tr5_reg [3];

    logic signed [XY_W-1:0] xf, yf;
    logic signed [XY_W:0]   xr, yr;
    logic signed [20:0]     c1;
    logic signed [56:0]     dtp;

    logic signed [39:0] ap [3][3];
    logic signed [44:0] bp [3][3];
    logic signed [59:0] wp [3];
    logic signed [29:0] rsum [3][3];
    logic signed [ROT_W-1:0] rsat [3][3];
    logic signed [19:0] imr [3][3];
    logic signed [56:0] tp [3][3];
    logic signed [45:0] acc [3];
    logic signed [TR_W-1:0] tsat [3];

    always_comb
    begin
        xf  = cin.flip ? -cin.x : cin.x;
        yf  = cin.flip ? -cin.y : cin.y;
        xr  = 35'(xf) + 35'sd8192;
        yr  = 35'(yf) + 35'sd8192;
        c1  = xr[34:Q30_SHIFT];
        dtp = 57'(dot) * 57'(cin.theta) + 57'sd32768;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (i == j)
                begin
                    ap[i][j] = 40'sd32768;
                end
                else if ((i - j + 3) % 3 == 1)
                begin
                    ap[i][j] = 40'(axis[3 - i - j]) * 40'(s1_reg) + 40'sd32768;
                end
                else
                begin
                    ap[i][j] = 40'sd32768 - 40'(axis[3 - i - j]) * 40'(s1_reg);
                end
                bp[i][j] = 45'(sq[i][j]) * 45'(omc1_reg) + 45'sd32768;
            end
            wp[i] = 60'(axis[i]) * 60'(dt1_reg) + 60'sd32768;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                rsum[i][j] = 30'(a2_reg[i][j]) + 30'(b2_reg[i][j])
                           + ((i == j) ? 30'sd65536 : 30'sd0);
                if (rsum[i][j] > ROT_MAX)
                begin
                    rsat[i][j] = ROT_MAX[ROT_W-1:0];
                end
                else if (rsum[i][j] < ROT_MIN)
                begin
                    rsat[i][j] = ROT_MIN[ROT_W-1:0];
                end
                else
                begin
                    rsat[i][j] = rsum[i][j][ROT_W-1:0];
                end
                imr[i][j] = ((i == j) ? 20'sd65536 : 20'sd0) - 20'(rot3_reg[i][j]);
                tp[i][j]  = 57'(imr[i][j]) * 57'(wxv[j]) + 57'sd32768;
            end
            acc[i] = 46'(wdt4_reg[i]) + 46'(term4_reg[i][0]) + 46'(term4_reg[i][1])
                   + 46'(term4_reg[i][2]);
            if (acc[i] > TR_MAX)
            begin
                tsat[i] = TR_MAX[TR_W-1:0];
            end
            else if (acc[i] < TR_MIN)
            begin
                tsat[i] = TR_MIN[TR_W-1:0];
            end
            else
            begin
                tsat[i] = acc[i][TR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= cin.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg   <= yr[34:Q30_SHIFT];
            omc1_reg <= 22'sd65536 - 22'(c1);
            dt1_reg  <= dtp[56:FRAC_BITS];
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    a2_reg[i][j]    <= ap[i][j][39:FRAC_BITS];
                    b2_reg[i][j]    <= bp[i][j][44:FRAC_BITS];
                    rot3_reg[i][j]  <= rsat[i][j];
                    term4_reg[i][j] <= tp[i][j][56:FRAC_BITS];
                    rot4_reg[i][j]  <= rot3_reg[i][j];
                    rot5_reg[i][j]  <= rot4_reg[i][j];
                end
                wdt2_reg[i] <= wp[i][59:FRAC_BITS];
                wdt3_reg[i] <= wdt2_reg[i];
                wdt4_reg[i] <= wdt3_reg[i];
                tr5_reg[i]  <= tsat[i];
            end
        end
    end

    assign out_valid = v5_reg;
    assign rot       = rot5_reg;
    assign tr        = tr5_reg;

endmodule

>>> hw/rtl/twist_exponential_map_core.sv
// ----------------------------------------------------------------------------
// twist_exponential_map_core
// Exponential map of a screw twist: joint angle in, rotation and translation
// of the rigid transform out, by a chain of CORDIC cells and a fixed-point
// Rodrigues back end.
//
//   Channel  Handshake             Payload
//   cfg      cfg_valid/cfg_ready   cfg_index, cfg_data
//   in       in_valid/in_ready     angle
//   out      out_valid/out_ready   r00..r22, tr_x, tr_y, tr_z
//
// One angle is accepted per cycle unless the pipeline holds; it passes the
// angle reduction, CORDIC cell and back-end registers. The config registers
// are always ready; after a write the twist terms pass a product register
// and an output register. Reset clears every valid bit and loads the axis
// with z at one. While a result waits on out_ready the whole pipeline holds.
// ----------------------------------------------------------------------------
module twist_exponential_map_core #(
    parameter int CORDIC_STEPS = 18
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tem_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tem_pkg::LIN_W-1:0]             cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [tem_pkg::ANGLE_W-1:0]    angle,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [tem_pkg::ROT_W-1:0]      r00,
    output logic signed [tem_pkg::ROT_W-1:0]      r01,
    output logic signed [tem_pkg::ROT_W-1:0]      r02,
    output logic signed [tem_pkg::ROT_W-1:0]      r10,
    output logic signed [tem_pkg::ROT_W-1:0]      r11,
    output logic signed [tem_pkg::ROT_W-1:0]      r12,
    output logic signed [tem_pkg::ROT_W-1:0]      r20,
    output logic signed [tem_pkg::ROT_W-1:0]      r21,
    output logic signed [tem_pkg::ROT_W-1:0]      r22,
    output logic signed [tem_pkg::TR_W-1:0]       tr_x,
    output logic signed [tem_pkg::TR_W-1:0]       tr_y,
    output logic signed [tem_pkg::TR_W-1:0]       tr_z
);
    import tem_pkg::*;

    logic signed [LIN_W-1:0]  lin_reg [3];
    logic signed [AXIS_W-1:0] axis_reg [3];

    logic                      adv;
    logic                      r1_valid_reg;
    logic signed [ANGLE_W-1:0] r1_theta_reg;
    logic signed [T_W-1:0]     r1_t_reg;
    logic signed [T_W-1:0]     t_in;
    logic signed [T_W-1:0]     t1_next;
    cordic_t                   r2_reg;
    cordic_t                   r2_next;
    cordic_t                   chain [CORDIC_STEPS+1];

    logic signed [21:0]        sq [3][3];
    logic signed [35:0]        wxv [3];
    logic signed [35:0]        dot;
    logic signed [ROT_W-1:0]   rot [3][3];
    logic signed [TR_W-1:0]    tr [3];

    assign adv       = !out_valid || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_reg[0]  <= '0;
            lin_reg[1]  <= '0;
            lin_reg[2]  <= '0;
            axis_reg[0] <= '0;
            axis_reg[1] <= '0;
            axis_reg[2] <= 18'sd65536;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LIN_X:  lin_reg[0]  <= cfg_data;
                REG_LIN_Y:  lin_reg[1]  <= cfg_data;
                REG_LIN_Z:  lin_reg[2]  <= cfg_data;
                REG_AXIS_X: axis_reg[0] <= cfg_data[AXIS_W-1:0];
                REG_AXIS_Y: axis_reg[1] <= cfg_data[AXIS_W-1:0];
                REG_AXIS_Z: axis_reg[2] <= cfg_data[AXIS_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        t_in = T_W'(angle) <<< Q30_SHIFT;
        if (t_in > Q30_PI)
        begin
            t1_next = t_in - Q30_TWO_PI;
        end
        else if (t_in < -Q30_PI)
        begin
            t1_next = t_in + Q30_TWO_PI;
        end
        else
        begin
            t1_next = t_in;
        end
    end

    always_comb
    begin
        r2_next.valid = r1_valid_reg;
        r2_next.theta = r1_theta_reg;
        r2_next.x     = Q30_GAIN;
        r2_next.y     = '0;
        if (r1_t_reg > Q30_HALF_PI)
        begin
            r2_next.t    = r1_t_reg - Q30_PI;
            r2_next.flip = 1'b1;
        end
        else if (r1_t_reg < -Q30_HALF_PI)
        begin
            r2_next.t    = r1_t_reg + Q30_PI;
            r2_next.flip = 1'b1;
        end
        else
        begin
            r2_next.t    = r1_t_reg;
            r2_next.flip = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg <= 1'b0;
            r1_theta_reg <= '0;
            r1_t_reg     <= '0;
            r2_reg       <= '0;
        end
        else if (adv)
        begin
            r1_valid_reg <= in_valid;
            r1_theta_reg <= angle;
            r1_t_reg     <= t1_next;
            r2_reg       <= r2_next;
        end
    end

    assign chain[0] = r2_reg;

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cell
        tem_cordic_cell #(
            .STEP (k)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .cin   (chain[k]),
            .cout  (chain[k+1])
        );
    end

    tem_twist_terms u_terms (
        .clk  (clk),
        .axis (axis_reg),
        .lin  (lin_reg),
        .sq   (sq),
        .wxv  (wxv),
        .dot  (dot)
    );

    tem_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cin       (chain[CORDIC_STEPS]),
        .axis      (axis_reg),
        .sq        (sq),
        .wxv       (wxv),
        .dot       (dot),
        .out_valid (out_valid),
        .rot       (rot),
        .tr        (tr)
    );

    assign r00  = rot[0][0];
    assign r01  = rot[0][1];
    assign r02  = rot[0][2];
    assign r10  = rot[1][0];
    assign r11  = rot[1][1];
    assign r12  = rot[1][2];
    assign r20  = rot[2][0];
    assign r21  = rot[2][1];
    assign r22  = rot[2][2];
    assign tr_x = tr[0];
    assign tr_y = tr[1];
    assign tr_z = tr[2];

    // The reduced angle must lie within one half turn of zero.
    a_reduced_range : assert property (@(posedge clk) disable iff (!rst_n)
        r1_valid_reg |-> (r1_t_reg <= Q30_PI && r1_t_reg >= -Q30_PI))
        else $error("reduced angle out of range");

    // The CORDIC chain only sees angles within a quarter turn.
    a_folded_range : assert property (@(posedge clk) disable iff (!rst_n)
        chain[0].valid |-> (chain[0].t <= Q30_HALF_PI && chain[0].t >= -Q30_HALF_PI))
        else $error("folded angle out of range");

    // A stalled pipeline holds the first CORDIC stage.
    a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(chain[1]))
        else $error("CORDIC stage moved during a stall");

    // An axis z write lands in its register.
    a_axis_write : assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_index == REG_AXIS_Z) |=> axis_reg[2] == $past(cfg_data[AXIS_W-1:0]))
        else $error("axis z write lost");

endmodule
